// ===== hw/rtl/ffba_pkg.sv =====
// Shared types and fixed constants of the first-fit block allocator.
// Used by the table memory, the engine, the top level and the checker.
// No dependencies.
package ffba_pkg;

	// fixed layout constants
	localparam int HEADER_BYTES = 24;
	localparam int ALIGN_BYTES  = 16;
	localparam int ALIGN_LG     = 4;
	localparam int MIN_BLOCK    = HEADER_BYTES + ALIGN_BYTES;
	localparam logic [31:0] HEAP_SIZE_RST = 32'd65536;

	// configuration register indexes
	localparam logic REG_HEAP_BASE = 1'b0;
	localparam logic REG_HEAP_SIZE = 1'b1;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_MEM    = 3'd1,
		ST_ZERO_SIZE = 3'd2,
		ST_NOT_ALLOC = 3'd3,
		ST_BAD_CFG   = 3'd4
	} status_t;

	typedef struct packed {
		logic        command;
		logic [31:0] request_size;
		logic [31:0] free_address;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] granted_address;
		logic [31:0] bytes_allocated;
		logic [31:0] bytes_free;
	} res_t;

	// one row of the block table
	typedef struct packed {
		logic [31:0] offset;
		logic [31:0] length;
		logic        used;
	} entry_t;

endpackage

// ===== hw/rtl/first_fit_block_allocator.sv =====
// First-fit heap block allocator, top level: configuration registers,
// block table memory and command engine. Depends on ffba_pkg.
//   Commands: drive cmd and raise start; the beat is taken at an edge where
//   start is high and busy is low. busy stays high while the command runs.
//   Results: done is high for exactly one cycle with the result beat on
//   result; the receiver cannot stall it. One result follows every command.
//   Configuration: cfg_we with cfg_index 0 (heap_base) or 1 (heap_size);
//   writing heap_size resets the table to one free block. Write only while
//   busy is low and no command is being started.
// Command sequence (k = row where the scan stops, n = rows in the table):
//   bad config or zero size: result in the cycle after the command is taken.
//   allocate: scan rows 0 to k; for a split, move each later row on by one to
//   open the gap and write the remainder row; then write the grant. No fit:
//   all n rows scanned. free: scan to find the row, read its neighbours,
//   merge and finish, moving later rows back to close the gap if any merged;
//   unknown address: all n rows scanned. Scan and row moves go one row at a
//   time. First command after reset or a heap_size write first seeds row 0
//   in S_INIT. A new command may start while done is high.
// Reset: heap_base 0, heap_size 65536, one free block of 65536 bytes.
module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  cmd_t        cmd,
	output logic        busy,
	output logic        done,
	output res_t        result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	logic [31:0]   heap_base_q;
	logic [31:0]   heap_size_q;
	logic          reinit;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	entry_t        ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
			heap_size_q <= HEAP_SIZE_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_HEAP_BASE) begin
				heap_base_q <= cfg_wdata;
			end else begin
				heap_size_q <= cfg_wdata;
			end
		end
	end

	assign reinit = cfg_we && (cfg_index == REG_HEAP_SIZE);

	ffba_table_ram #(
		.DEPTH (MAX_BLOCKS),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ffba_engine #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.IW         (IW)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.busy        (busy),
		.done        (done),
		.result      (result),
		.reinit      (reinit),
		.reinit_size (cfg_wdata),
		.heap_base   (heap_base_q),
		.heap_size   (heap_size_q),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

endmodule

// ===== hw/rtl/ffba_table_ram.sv =====
// Block table memory: one write port, one read port, registered read data.
// Depends on ffba_pkg (entry_t).
module ffba_table_ram import ffba_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/ffba_engine.sv =====
// Command sequencer: scans the block table, splits, merges and shifts rows,
// keeps the running totals and forms the result beat. Depends on ffba_pkg.
module ffba_engine import ffba_pkg::*; #(
	parameter int MAX_BLOCKS = 64,
	parameter int IW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cmd_t          cmd,
	output logic          busy,
	output logic          done,
	output res_t          result,
	input  logic          reinit,
	input  logic [31:0]   reinit_size,
	input  logic [31:0]   heap_base,
	input  logic [31:0]   heap_size,
	output logic          ram_we,
	output logic [IW-1:0] ram_waddr,
	output entry_t        ram_wdata,
	output logic          ram_re,
	output logic [IW-1:0] ram_raddr,
	input  entry_t        ram_rdata
);

	localparam int CW = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_INIT  = 15'b000000000000010,
		S_SCAN  = 15'b000000000000100,
		S_UPRD  = 15'b000000000001000,
		S_UPWR  = 15'b000000000010000,
		S_SPLIT = 15'b000000000100000,
		S_GRANT = 15'b000000001000000,
		S_NXTRD = 15'b000000010000000,
		S_NXTWT = 15'b000000100000000,
		S_PRVRD = 15'b000001000000000,
		S_PRVWT = 15'b000010000000000,
		S_MERGE = 15'b000100000000000,
		S_DNCK  = 15'b001000000000000,
		S_DNRD  = 15'b010000000000000,
		S_DNWR  = 15'b100000000000000
	} state_t;

	state_t        state_q;
	logic          fresh_q;
	logic [CW-1:0] count_q;
	logic [31:0]   in_use_q;
	logic [31:0]   avail_q;
	logic          is_free_q;
	logic [33:0]   need_q;
	logic [31:0]   addr_q;
	logic [CW-1:0] scan_q;
	logic          chk_vld_q;
	logic [IW-1:0] chk_idx_q;
	logic [IW-1:0] idx_q;
	entry_t        ent_q;
	entry_t        nxt_q;
	entry_t        prv_q;
	logic          nf_q;
	logic          pf_q;
	logic          split_q;
	logic [CW-1:0] j_q;
	logic          sh2_q;
	logic          shift_q;
	logic          done_q;
	res_t          res_q;

	logic [33:0]   need_sum;
	logic [33:0]   need_rnd;
	logic [33:0]   need_c;
	logic          bad_cfg;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] idx_c;
	logic [CW-1:0] idx_p1;
	logic [CW-1:0] chk_c;
	logic [CW-1:0] shamt;
	logic [CW-1:0] j_p1;
	logic [CW-1:0] j_ps;
	logic [IW-1:0] idx_m1;
	logic [31:0]   user_rd;
	logic          hit;
	logic          split_now;
	logic [31:0]   blen;
	logic [31:0]   nxt_len;
	logic [31:0]   mrg_len;

	// request size to block size: add header, round up, apply minimum; flag bad config
	always_comb begin
		need_sum = 34'(cmd.request_size) + 34'(HEADER_BYTES + ALIGN_BYTES - 1);
		need_rnd = {need_sum[33:ALIGN_LG], {ALIGN_LG{1'b0}}};
		need_c   = (need_rnd < 34'(MIN_BLOCK)) ? 34'(MIN_BLOCK) : need_rnd;
		bad_cfg  = (heap_base[ALIGN_LG-1:0] != '0) || (heap_size < 32'(MIN_BLOCK));
	end

	// index arithmetic
	always_comb begin
		cnt_m1  = count_q - CW'(1);
		idx_c   = CW'(idx_q);
		idx_p1  = idx_c + CW'(1);
		chk_c   = CW'(chk_idx_q);
		shamt   = sh2_q ? CW'(2) : CW'(1);
		j_p1    = j_q + CW'(1);
		j_ps    = j_q + shamt;
		idx_m1  = idx_q - IW'(1);
	end

	// row match during the scan, split test and merged lengths
	always_comb begin
		user_rd   = heap_base + ram_rdata.offset + 32'(HEADER_BYTES);
		if (is_free_q) begin
			hit = ram_rdata.used && (user_rd == addr_q);
		end else begin
			hit = !ram_rdata.used && ({2'b00, ram_rdata.length} >= need_q);
		end
		split_now = ({3'b000, ram_rdata.length} >= ({1'b0, need_q} + 35'(MIN_BLOCK)))
			&& (count_q < CW'(MAX_BLOCKS));
		blen    = split_q ? need_q[31:0] : ent_q.length;
		nxt_len = nf_q ? nxt_q.length : 32'd0;
		mrg_len = ent_q.length + nxt_len;
	end

	// table memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = '{offset: 32'd0, length: heap_size, used: 1'b0};
			end
			S_SCAN: begin
				ram_re    = scan_q < count_q;
				ram_raddr = scan_q[IW-1:0];
			end
			S_UPRD: begin
				ram_re    = 1'b1;
				ram_raddr = j_q[IW-1:0];
			end
			S_UPWR: begin
				ram_we    = 1'b1;
				ram_waddr = j_p1[IW-1:0];
				ram_wdata = ram_rdata;
			end
			S_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = idx_p1[IW-1:0];
				ram_wdata = '{offset: ent_q.offset + need_q[31:0],
					length: ent_q.length - need_q[31:0], used: 1'b0};
			end
			S_GRANT: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = '{offset: ent_q.offset, length: blen, used: 1'b1};
			end
			S_NXTRD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_p1[IW-1:0];
			end
			S_PRVRD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_m1;
			end
			S_MERGE: begin
				ram_we = 1'b1;
				if (pf_q) begin
					ram_waddr = idx_m1;
					ram_wdata = '{offset: prv_q.offset, length: prv_q.length + mrg_len,
						used: 1'b0};
				end else begin
					ram_waddr = idx_q;
					ram_wdata = '{offset: ent_q.offset, length: mrg_len, used: 1'b0};
				end
			end
			S_DNRD: begin
				ram_re    = 1'b1;
				ram_raddr = j_ps[IW-1:0];
			end
			S_DNWR: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[IW-1:0];
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fresh_q   <= 1'b1;
			count_q   <= CW'(1);
			in_use_q  <= '0;
			avail_q   <= HEAP_SIZE_RST;
			is_free_q <= 1'b0;
			need_q    <= '0;
			addr_q    <= '0;
			scan_q    <= '0;
			chk_vld_q <= 1'b0;
			chk_idx_q <= '0;
			idx_q     <= '0;
			ent_q     <= '0;
			nxt_q     <= '0;
			prv_q     <= '0;
			nf_q      <= 1'b0;
			pf_q      <= 1'b0;
			split_q   <= 1'b0;
			j_q       <= '0;
			sh2_q     <= 1'b0;
			shift_q   <= 1'b0;
			done_q    <= 1'b0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					// heap_size write: table back to one free block
					if (reinit) begin
						count_q  <= CW'(1);
						in_use_q <= '0;
						avail_q  <= reinit_size;
						fresh_q  <= 1'b1;
					end
					if (start) begin
						is_free_q <= cmd.command;
						addr_q    <= cmd.free_address;
						need_q    <= need_c;
						scan_q    <= '0;
						chk_vld_q <= 1'b0;
						if (bad_cfg) begin
							done_q <= 1'b1;
							res_q  <= '{ST_BAD_CFG, 32'd0, in_use_q, avail_q};
						end else if (cmd.command == CMD_ALLOC && cmd.request_size == '0) begin
							done_q <= 1'b1;
							res_q  <= '{ST_ZERO_SIZE, 32'd0, in_use_q, avail_q};
						end else begin
							state_q <= fresh_q ? S_INIT : S_SCAN;
						end
					end
				end
				S_INIT: begin
					fresh_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// reads issue every cycle up to the last row; each row is checked when its registered read data returns
					scan_q    <= scan_q + CW'(ram_re);
					chk_vld_q <= ram_re;
					chk_idx_q <= scan_q[IW-1:0];
					if (chk_vld_q) begin
						if (hit) begin
							ent_q <= ram_rdata;
							idx_q <= chk_idx_q;
							nf_q  <= 1'b0;
							pf_q  <= 1'b0;
							if (is_free_q) begin
								if (chk_c + CW'(1) < count_q) begin
									state_q <= S_NXTRD;
								end else if (chk_idx_q != '0) begin
									state_q <= S_PRVRD;
								end else begin
									state_q <= S_MERGE;
								end
							end else begin
								split_q <= split_now;
								j_q     <= cnt_m1;
								if (!split_now) begin
									state_q <= S_GRANT;
								end else if (cnt_m1 > chk_c) begin
									state_q <= S_UPRD;
								end else begin
									state_q <= S_SPLIT;
								end
							end
						end else if (chk_c == cnt_m1) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
							res_q   <= '{is_free_q ? ST_NOT_ALLOC : ST_NO_MEM, 32'd0,
								in_use_q, avail_q};
						end
					end
				end
				// open a gap after the chosen row, one row per S_UPRD/S_UPWR pair
				S_UPRD: begin
					state_q <= S_UPWR;
				end
				S_UPWR: begin
					j_q     <= j_q - CW'(1);
					state_q <= ((j_q - CW'(1)) > idx_c) ? S_UPRD : S_SPLIT;
				end
				S_SPLIT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_GRANT;
				end
				S_GRANT: begin
					in_use_q <= in_use_q + blen;
					avail_q  <= avail_q - blen;
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					res_q    <= '{ST_OK, heap_base + ent_q.offset + 32'(HEADER_BYTES),
						in_use_q + blen, avail_q - blen};
				end
				// neighbour fetch for coalescing
				S_NXTRD: begin
					state_q <= S_NXTWT;
				end
				S_NXTWT: begin
					nxt_q   <= ram_rdata;
					nf_q    <= !ram_rdata.used;
					state_q <= (idx_q != '0) ? S_PRVRD : S_MERGE;
				end
				S_PRVRD: begin
					state_q <= S_PRVWT;
				end
				S_PRVWT: begin
					prv_q   <= ram_rdata;
					pf_q    <= !ram_rdata.used;
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					in_use_q <= in_use_q - ent_q.length;
					avail_q  <= avail_q + ent_q.length;
					if (pf_q) begin
						j_q     <= idx_c;
						sh2_q   <= nf_q;
						shift_q <= 1'b1;
					end else begin
						j_q     <= idx_p1;
						sh2_q   <= 1'b0;
						shift_q <= nf_q;
					end
					state_q <= S_DNCK;
				end
				// close the hole left by merged rows
				S_DNCK: begin
					if (shift_q && (j_ps < count_q)) begin
						state_q <= S_DNRD;
					end else begin
						if (shift_q) begin
							count_q <= count_q - shamt;
						end
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= '{ST_OK, 32'd0, in_use_q, avail_q};
					end
				end
				S_DNRD: begin
					state_q <= S_DNWR;
				end
				S_DNWR: begin
					j_q     <= j_p1;
					state_q <= S_DNCK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== hw/rtl/ffba_checker.sv =====
// Port-level checks of the allocator, attached to the top level by bind.
// Depends on ffba_pkg and first_fit_block_allocator.
module ffba_checker import ffba_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t result
);

	// an accepted command either finishes at once or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither busy nor done");

	// a result beat only ends a command
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && !busy)))
		else $error("result beat without a command");

	// the engine is free when it reports
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// failed commands grant nothing
	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.granted_address == 32'd0))
		else $error("address granted with error status");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== bench/tb_first_fit_block_allocator.sv =====
// Self-checking bench for first_fit_block_allocator: predicts each result from a
// behavioural copy of the block table and compares it field by field.
// Depends on ffba_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_first_fit_block_allocator;
	import ffba_pkg::*;

	localparam int TBL_ROWS = 64;

	logic        clk;
	logic        arst_n;
	logic        start;
	cmd_t        cmd;
	logic        busy;
	logic        done;
	res_t        result;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_wdata;

	first_fit_block_allocator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state: heap registers and a copy of the block table
	logic [31:0] heap_base_q, heap_size_q;
	logic [31:0] row_off [TBL_ROWS];
	logic [31:0] row_len [TBL_ROWS];
	logic        row_used [TBL_ROWS];
	int          row_cnt;
	logic [31:0] in_use_sum, avail_sum;

	cmd_t   pending_cmds[$];
	res_t   expected_results[$];
	int     fail_cnt, beats_sent, beats_seen, n_alloc_ok, n_free_ok;

	always #1 clk = ~clk;

	function automatic void table_reset();
		for (int i = 0; i < TBL_ROWS; i++) begin
			row_off[i] = '0; row_len[i] = '0; row_used[i] = 1'b0;
		end
		row_len[0] = heap_size_q;
		row_cnt = 1;
		in_use_sum = '0;
		avail_sum = heap_size_q;
	endfunction

	function automatic void row_drop(int k);
		for (int j = k; j + 1 < row_cnt; j++) begin
			row_off[j] = row_off[j+1]; row_len[j] = row_len[j+1];
			row_used[j] = row_used[j+1];
		end
		if (row_cnt > 1) row_cnt--;
	endfunction

	function automatic logic [31:0] user_address(int k);
		return heap_base_q + row_off[k] + 32'(HEADER_BYTES);
	endfunction

	// work out the result of one command and update the table copy
	function automatic res_t heap_outcome(cmd_t c);
		res_t        r;
		logic [33:0] need;
		int          k;
		r = '0;
		if (heap_base_q[3:0] != 0 || heap_size_q < 32'(MIN_BLOCK)) begin
			r.status = ST_BAD_CFG;
		end else if (c.command == CMD_ALLOC) begin
			if (c.request_size == 0) begin
				r.status = ST_ZERO_SIZE;
			end else begin
				need = 34'(c.request_size) + HEADER_BYTES + ALIGN_BYTES - 1;
				need[3:0] = 4'd0;
				if (need < MIN_BLOCK) need = MIN_BLOCK;
				r.status = ST_NO_MEM;
				for (int i = 0; i < row_cnt; i++) begin
					if (!row_used[i] && 34'(row_len[i]) >= need) begin
						if (34'(row_len[i]) >= need + MIN_BLOCK && row_cnt < TBL_ROWS) begin
							for (int j = row_cnt; j > i + 1; j--) begin
								row_off[j] = row_off[j-1]; row_len[j] = row_len[j-1];
								row_used[j] = row_used[j-1];
							end
							row_off[i+1] = row_off[i] + need[31:0];
							row_len[i+1] = row_len[i] - need[31:0];
							row_used[i+1] = 1'b0;
							row_len[i] = need[31:0];
							row_cnt++;
						end
						row_used[i] = 1'b1;
						in_use_sum += row_len[i];
						avail_sum -= row_len[i];
						r.status = ST_OK;
						r.granted_address = user_address(i);
						break;
					end
				end
			end
		end else begin
			k = -1;
			for (int i = 0; i < row_cnt; i++)
				if (row_used[i] && user_address(i) == c.free_address) begin
					k = i;
					break;
				end
			if (k < 0) begin
				r.status = ST_NOT_ALLOC;
			end else begin
				r.status = ST_OK;
				row_used[k] = 1'b0;
				in_use_sum -= row_len[k];
				avail_sum += row_len[k];
				if (k + 1 < row_cnt && !row_used[k+1]) begin
					row_len[k] += row_len[k+1];
					row_drop(k + 1);
				end
				if (k > 0 && !row_used[k-1]) begin
					row_len[k-1] += row_len[k];
					row_drop(k);
				end
			end
		end
		r.bytes_allocated = in_use_sum;
		r.bytes_free = avail_sum;
		return r;
	endfunction

	// live user addresses, so frees mostly hit real blocks
	logic [31:0] live_addrs[$];

	// driver: one beat from the queue, random gap before each
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap_left <= 0;
		end else if (start && !busy) begin
			expected_results.push_back(heap_outcome(cmd));
			beats_sent++;
			start <= 1'b0;
			gap_left <= $urandom_range(0, 13);
		end else if (!start) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() > 0) begin
				cmd <= pending_cmds.pop_front();
				start <= 1'b1;
			end
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			beats_seen++;
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected");
				fail_cnt++;
			end else begin
				e = expected_results.pop_front();
				if (result.status != e.status) begin
					$error("status exp %0d got %0d", e.status, result.status); fail_cnt++;
				end
				if (result.granted_address != e.granted_address) begin
					$error("granted_address exp %h got %h", e.granted_address,
						result.granted_address);
					fail_cnt++;
				end
				if (result.bytes_allocated != e.bytes_allocated) begin
					$error("bytes_allocated exp %h got %h", e.bytes_allocated,
						result.bytes_allocated);
					fail_cnt++;
				end
				if (result.bytes_free != e.bytes_free) begin
					$error("bytes_free exp %h got %h", e.bytes_free, result.bytes_free);
					fail_cnt++;
				end
				if (e.status == ST_OK && e.granted_address != 0) begin
					live_addrs.push_back(e.granted_address);
					n_alloc_ok++;
				end else if (e.status == ST_OK) begin
					n_free_ok++;
				end
			end
		end
	end

	task automatic queue_cmd(logic op, logic [31:0] req, logic [31:0] addr);
		cmd_t c;
		c.command = op; c.request_size = req; c.free_address = addr;
		pending_cmds.push_back(c);
	endtask

	// wait until every queued beat is sent and answered, then let the engine settle
	task automatic drain();
		while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_wdata <= val;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HEAP_BASE) heap_base_q = val;
		else begin
			heap_size_q = val;
			table_reset();
		end
		live_addrs.delete();
		@(posedge clk);
	endtask

	// random request size, mostly small, sometimes huge
	function automatic logic [31:0] rand_size();
		case ($urandom_range(0, 19))
			0:       return $urandom();
			1:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
			2:       return $urandom_range(1, 8);
			default: return $urandom_range(1, 1500);
		endcase
	endfunction

	// one random phase: allocs, zero-size allocs, frees of live blocks, stray frees
	task automatic random_phase(int n);
		int idx;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: queue_cmd(CMD_ALLOC, rand_size(), $urandom());
				4, 5, 6, 7: begin
					while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
						@(posedge clk);
					if (live_addrs.size() > 0) begin
						idx = $urandom_range(0, live_addrs.size() - 1);
						queue_cmd(CMD_FREE, $urandom(), live_addrs[idx]);
						live_addrs.delete(idx);
					end else begin
						queue_cmd(CMD_ALLOC, rand_size(), $urandom());
					end
				end
				8: queue_cmd(CMD_FREE, $urandom(), $urandom());
				default: queue_cmd(CMD_ALLOC, 0, $urandom());
			endcase
			if ($urandom_range(0, 3) == 0) @(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HEAP_BASE;
		cfg_wdata = '0;
		fail_cnt = 0; beats_sent = 0; beats_seen = 0; n_alloc_ok = 0; n_free_ok = 0;
		heap_base_q = '0;
		heap_size_q = HEAP_SIZE_RST;
		table_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset heap, extremes, zero size, stray and double free
		queue_cmd(CMD_ALLOC, 0, '0);
		queue_cmd(CMD_ALLOC, 1, '0);
		queue_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(CMD_ALLOC, 32'd40, '0);
		queue_cmd(CMD_ALLOC, 32'd65512, '0);
		queue_cmd(CMD_ALLOC, 32'd100, '0);
		queue_cmd(CMD_FREE, 32'hFFFF_FFFF, 32'd24);
		queue_cmd(CMD_FREE, '0, 32'd24);
		queue_cmd(CMD_FREE, '0, 32'hFFFF_FFFF);
		queue_cmd(CMD_FREE, '0, 32'd64);
		queue_cmd(CMD_ALLOC, 32'd65000, '0);
		drain();

		// bad config: misaligned base, then heap too small
		write_reg(REG_HEAP_BASE, 32'h0000_0008);
		queue_cmd(CMD_ALLOC, 32'd16, '0);
		queue_cmd(CMD_FREE, '0, 32'd32);
		drain();
		write_reg(REG_HEAP_BASE, 32'hFFFF_FFF0);
		write_reg(REG_HEAP_SIZE, 32'd39);
		queue_cmd(CMD_ALLOC, 32'd1, '0);
		drain();

		// smallest heap, address wrap at top of space
		write_reg(REG_HEAP_SIZE, 32'd40);
		queue_cmd(CMD_ALLOC, 32'd16, '0);
		queue_cmd(CMD_ALLOC, 32'd1, '0);
		queue_cmd(CMD_FREE, '0, 32'h0000_0008);
		queue_cmd(CMD_FREE, '0, 32'h0000_0008);
		drain();

		// full-size heap; table fills, so whole-block grants happen
		write_reg(REG_HEAP_SIZE, 32'hFFFF_FFFF);
		for (int i = 0; i < 70; i++) queue_cmd(CMD_ALLOC, 32'd8, '0);
		drain();
		random_phase(120);
		drain();

		// default-size heap at a mid base
		write_reg(REG_HEAP_BASE, 32'h8000_0000);
		write_reg(REG_HEAP_SIZE, 32'd65536);
		random_phase(350);
		drain();

		// small heap, lots of no-memory answers and merging
		write_reg(REG_HEAP_BASE, 32'h0000_1230);
		write_reg(REG_HEAP_SIZE, 32'd3000);
		random_phase(300);
		drain();

		$display("%0d commands sent, %0d results checked: %0d grants, %0d frees",
			beats_sent, beats_seen, n_alloc_ok, n_free_ok);
		if (fail_cnt == 0) $display("tb_first_fit_block_allocator OK");
		else $display("tb_first_fit_block_allocator NOT OK");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#2000000;
		$display("tb_first_fit_block_allocator NOT OK");
		$finish;
	end

endmodule
